// File: design/hup_pkg.sv
// Shared types and constants of the HTTP URL stream parser.
package hup_pkg;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Port numbers.
    localparam logic [16:0] PORT_MAX   = 17'd65535;
    localparam logic [16:0] PORT_SAT   = 17'd65536;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_HTTP  = 16'd80;

    // Role tags of a byte.
    localparam logic [2:0] ROLE_SCHEME  = 3'd0;
    localparam logic [2:0] ROLE_SEP     = 3'd1;
    localparam logic [2:0] ROLE_HOST    = 3'd2;
    localparam logic [2:0] ROLE_BRACKET = 3'd3;
    localparam logic [2:0] ROLE_PORT    = 3'd4;
    localparam logic [2:0] ROLE_PATH    = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    // Queue between classifier and parser.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Character classes as seen by the parser.
    typedef enum logic [3:0] {
        CLS_NUL,
        CLS_COLON,
        CLS_SLASH,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_DIGIT,
        CLS_SPACE,
        CLS_PLUS,
        CLS_MINUS,
        CLS_H,
        CLS_T,
        CLS_P,
        CLS_S,
        CLS_OTHER
    } t_cls;

    // One classified word in the queue.
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       is_end;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [2:0]  byte_role;
        logic        done_res;
        logic        url_ok;
        logic        is_https;
        logic [15:0] port_number;
        logic        path_defaulted;
        logic [7:0]  host_length;
        logic [9:0]  path_length;
    } t_result;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_SCHEME     = 11'b000_0000_0001,
        PH_SCHEME_END = 11'b000_0000_0010,
        PH_COLON      = 11'b000_0000_0100,
        PH_SLASH1     = 11'b000_0000_1000,
        PH_SLASH2     = 11'b000_0001_0000,
        PH_HOST_FIRST = 11'b000_0010_0000,
        PH_HOST       = 11'b000_0100_0000,
        PH_BRACKET    = 11'b000_1000_0000,
        PH_AFTER_HOST = 11'b001_0000_0000,
        PH_PORT       = 11'b010_0000_0000,
        PH_PATH       = 11'b100_0000_0000
    } t_phase;

endpackage

// File: design/hup_ifs.sv
// Handshake interfaces for the URL byte channel and the result channel.
interface hup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_end;

    modport source (output valid, output char_byte, output is_end, input ready);
    modport sink   (input valid, input char_byte, input is_end, output ready);
endinterface

interface hup_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic        done_res;
    logic        url_ok;
    logic        is_https;
    logic [15:0] port_number;
    logic        path_defaulted;
    logic [7:0]  host_length;
    logic [9:0]  path_length;

    modport source (output valid, output byte_role, output done_res, output url_ok,
                    output is_https, output port_number, output path_defaulted,
                    output host_length, output path_length, input ready);
    modport sink   (input valid, input byte_role, input done_res, input url_ok,
                    input is_https, input port_number, input path_defaulted,
                    input host_length, input path_length, output ready);
endinterface

// File: design/hup_front.sv
// Front end: classifies each incoming byte into a character class.
module hup_front (
    input  logic [7:0]    i_char_byte,
    input  logic          i_is_end,
    output hup_pkg::t_item o_item
);

    logic [7:0] lower;

    // Fold upper-case letters to lower case.
    always_comb begin
        if (i_char_byte >= hup_pkg::CH_UPPER_A && i_char_byte <= hup_pkg::CH_UPPER_Z) begin
            lower = i_char_byte + hup_pkg::CASE_OFFSET;
        end else begin
            lower = i_char_byte;
        end
    end

    // Map the byte to its class; digits also carry their value.
    always_comb begin
        o_item.is_end = i_is_end;
        o_item.digit  = 4'(i_char_byte - hup_pkg::CH_ZERO);
        if (i_char_byte >= hup_pkg::CH_ZERO && i_char_byte <= hup_pkg::CH_NINE) begin
            o_item.cls = hup_pkg::CLS_DIGIT;
        end else if (i_char_byte >= hup_pkg::CH_TAB && i_char_byte <= hup_pkg::CH_CR) begin
            o_item.cls = hup_pkg::CLS_SPACE;
        end else begin
            case (lower)
                hup_pkg::CH_NUL:     o_item.cls = hup_pkg::CLS_NUL;
                hup_pkg::CH_SPACE:   o_item.cls = hup_pkg::CLS_SPACE;
                hup_pkg::CH_COLON:   o_item.cls = hup_pkg::CLS_COLON;
                hup_pkg::CH_SLASH:   o_item.cls = hup_pkg::CLS_SLASH;
                hup_pkg::CH_LBRACK:  o_item.cls = hup_pkg::CLS_LBRACK;
                hup_pkg::CH_RBRACK:  o_item.cls = hup_pkg::CLS_RBRACK;
                hup_pkg::CH_PLUS:    o_item.cls = hup_pkg::CLS_PLUS;
                hup_pkg::CH_MINUS:   o_item.cls = hup_pkg::CLS_MINUS;
                hup_pkg::CH_LOWER_H: o_item.cls = hup_pkg::CLS_H;
                hup_pkg::CH_LOWER_T: o_item.cls = hup_pkg::CLS_T;
                hup_pkg::CH_LOWER_P: o_item.cls = hup_pkg::CLS_P;
                hup_pkg::CH_LOWER_S: o_item.cls = hup_pkg::CLS_S;
                default:             o_item.cls = hup_pkg::CLS_OTHER;
            endcase
        end
    end

endmodule

// File: design/hup_queue.sv
// Short FIFO of classified words between the front end and the parser.
module hup_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hup_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hup_pkg::t_item o_item
);

    localparam int CW = hup_pkg::QUEUE_AW + 1;

    hup_pkg::t_item              r_mem [hup_pkg::QUEUE_DEPTH];
    logic [hup_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [hup_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;

    assign o_full  = (r_count == CW'(hup_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + hup_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + hup_pkg::QUEUE_AW'(1);
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/hup_back.sv
// Back end: the URL parsing state machine and the registered result word.
module hup_back #(
    parameter int HOST_BYTES = 256,
    parameter int PATH_BYTES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hup_pkg::t_item   i_item,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output hup_pkg::t_result o_result
);

    localparam int HC_W = $clog2(HOST_BYTES + 1);
    localparam int PC_W = $clog2(PATH_BYTES + 1);

    hup_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_scheme_count, n_scheme_count;
    logic             r_https, n_https;
    logic             r_err, n_err;
    logic             r_term, n_term;
    logic [HC_W-1:0]  r_host_count, n_host_count;
    logic [PC_W-1:0]  r_path_count, n_path_count;
    logic [16:0]      r_accum, n_accum;
    logic             r_sign, n_sign;
    logic             r_neg, n_neg;
    logic             r_digit, n_digit;
    logic             r_out_valid;
    hup_pkg::t_result r_out, n_out;

    logic [HC_W-1:0]  host_inc;
    logic [PC_W-1:0]  path_inc;
    logic [19:0]      accum_mul;
    logic [16:0]      accum_sat;
    logic             host_full;
    logic             path_full;
    logic             port_ok;
    logic             fin_err;
    logic             done_err;
    logic             scheme_hit;
    logic [2:0]       role;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Counter steps and the decimal accumulate, saturating at 65536.
    assign host_inc  = r_host_count + HC_W'(1);
    assign path_inc  = r_path_count + PC_W'(1);
    assign host_full = (host_inc >= HC_W'(HOST_BYTES));
    assign path_full = (path_inc >= PC_W'(PATH_BYTES));
    assign accum_mul = {r_accum, 3'b000} + {2'b00, r_accum, 1'b0} + 20'(i_item.digit);
    assign accum_sat = (accum_mul > 20'(hup_pkg::PORT_SAT)) ? hup_pkg::PORT_SAT
                                                           : accum_mul[16:0];

    assign port_ok = r_digit && !r_neg && (r_accum != '0) && (r_accum <= hup_pkg::PORT_MAX);

    // Error state once the URL text ends in the current phase.
    assign fin_err = r_err || !((r_phase == hup_pkg::PH_HOST) ||
                                (r_phase == hup_pkg::PH_AFTER_HOST) ||
                                (r_phase == hup_pkg::PH_PATH) ||
                                ((r_phase == hup_pkg::PH_PORT) && port_ok));
    assign done_err = r_term ? r_err : fin_err;

    // Expected scheme letter for the current position of "http".
    assign scheme_hit = ((r_scheme_count == 3'd0) && (i_item.cls == hup_pkg::CLS_H)) ||
                        ((r_scheme_count == 3'd1) && (i_item.cls == hup_pkg::CLS_T)) ||
                        ((r_scheme_count == 3'd2) && (i_item.cls == hup_pkg::CLS_T)) ||
                        ((r_scheme_count == 3'd3) && (i_item.cls == hup_pkg::CLS_P));

    // Next state and the result word of the popped item.
    always_comb begin
        n_phase        = r_phase;
        n_scheme_count = r_scheme_count;
        n_https        = r_https;
        n_err          = r_err;
        n_term         = r_term;
        n_host_count   = r_host_count;
        n_path_count   = r_path_count;
        n_accum        = r_accum;
        n_sign         = r_sign;
        n_neg          = r_neg;
        n_digit        = r_digit;
        role           = hup_pkg::ROLE_IGNORED;
        n_out          = '0;

        if (!i_item.is_end) begin
            if (!r_term && !r_err) begin
                if (i_item.cls == hup_pkg::CLS_NUL) begin
                    n_term = 1'b1;
                    n_err  = fin_err;
                end else begin
                    case (r_phase)
                        hup_pkg::PH_SCHEME: begin
                            if (scheme_hit) begin
                                n_scheme_count = r_scheme_count + 3'd1;
                                if (r_scheme_count == 3'd3) begin
                                    n_phase = hup_pkg::PH_SCHEME_END;
                                end
                                role = hup_pkg::ROLE_SCHEME;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_SCHEME_END: begin
                            if (i_item.cls == hup_pkg::CLS_S) begin
                                n_https = 1'b1;
                                n_phase = hup_pkg::PH_COLON;
                                role    = hup_pkg::ROLE_SCHEME;
                            end else if (i_item.cls == hup_pkg::CLS_COLON) begin
                                n_phase = hup_pkg::PH_SLASH1;
                                role    = hup_pkg::ROLE_SEP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_COLON: begin
                            if (i_item.cls == hup_pkg::CLS_COLON) begin
                                n_phase = hup_pkg::PH_SLASH1;
                                role    = hup_pkg::ROLE_SEP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_SLASH1: begin
                            if (i_item.cls == hup_pkg::CLS_SLASH) begin
                                n_phase = hup_pkg::PH_SLASH2;
                                role    = hup_pkg::ROLE_SEP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_SLASH2: begin
                            if (i_item.cls == hup_pkg::CLS_SLASH) begin
                                n_phase = hup_pkg::PH_HOST_FIRST;
                                role    = hup_pkg::ROLE_SEP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_HOST_FIRST: begin
                            if (i_item.cls == hup_pkg::CLS_SLASH ||
                                i_item.cls == hup_pkg::CLS_COLON) begin
                                n_err = 1'b1;
                            end else if (i_item.cls == hup_pkg::CLS_LBRACK) begin
                                n_phase = hup_pkg::PH_BRACKET;
                                role    = hup_pkg::ROLE_BRACKET;
                            end else begin
                                n_phase      = hup_pkg::PH_HOST;
                                n_host_count = host_inc;
                                if (host_full) begin
                                    n_err = 1'b1;
                                end else begin
                                    role = hup_pkg::ROLE_HOST;
                                end
                            end
                        end
                        hup_pkg::PH_HOST, hup_pkg::PH_AFTER_HOST: begin
                            if (i_item.cls == hup_pkg::CLS_COLON) begin
                                n_phase = hup_pkg::PH_PORT;
                                n_accum = '0;
                                n_sign  = 1'b0;
                                n_neg   = 1'b0;
                                n_digit = 1'b0;
                                role    = hup_pkg::ROLE_SEP;
                            end else if (i_item.cls == hup_pkg::CLS_SLASH) begin
                                n_phase      = hup_pkg::PH_PATH;
                                n_path_count = PC_W'(1);
                                if (PATH_BYTES <= 1) begin
                                    n_err = 1'b1;
                                end else begin
                                    role = hup_pkg::ROLE_PATH;
                                end
                            end else if (r_phase == hup_pkg::PH_HOST) begin
                                n_host_count = host_inc;
                                if (host_full) begin
                                    n_err = 1'b1;
                                end else begin
                                    role = hup_pkg::ROLE_HOST;
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_BRACKET: begin
                            if (i_item.cls == hup_pkg::CLS_RBRACK) begin
                                if (r_host_count == '0) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = hup_pkg::PH_AFTER_HOST;
                                    role    = hup_pkg::ROLE_BRACKET;
                                end
                            end else begin
                                n_host_count = host_inc;
                                if (host_full) begin
                                    n_err = 1'b1;
                                end else begin
                                    role = hup_pkg::ROLE_HOST;
                                end
                            end
                        end
                        hup_pkg::PH_PORT: begin
                            if (i_item.cls == hup_pkg::CLS_DIGIT) begin
                                n_digit = 1'b1;
                                n_accum = accum_sat;
                                role    = hup_pkg::ROLE_PORT;
                            end else if (!r_digit && !r_sign) begin
                                // Leading whitespace and one sign are allowed.
                                if (i_item.cls == hup_pkg::CLS_SPACE) begin
                                    role = hup_pkg::ROLE_PORT;
                                end else if (i_item.cls == hup_pkg::CLS_PLUS ||
                                             i_item.cls == hup_pkg::CLS_MINUS) begin
                                    n_sign = 1'b1;
                                    n_neg  = (i_item.cls == hup_pkg::CLS_MINUS);
                                    role   = hup_pkg::ROLE_PORT;
                                end else begin
                                    n_err = 1'b1;
                                end
                            end else if (r_digit && i_item.cls == hup_pkg::CLS_SLASH) begin
                                if (!port_ok) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_phase      = hup_pkg::PH_PATH;
                                    n_path_count = PC_W'(1);
                                    if (PATH_BYTES <= 1) begin
                                        n_err = 1'b1;
                                    end else begin
                                        role = hup_pkg::ROLE_PATH;
                                    end
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        hup_pkg::PH_PATH: begin
                            n_path_count = path_inc;
                            if (path_full) begin
                                n_err = 1'b1;
                            end else begin
                                role = hup_pkg::ROLE_PATH;
                            end
                        end
                        default: begin
                            n_err = 1'b1;
                        end
                    endcase
                end
            end
            n_out.byte_role = role;
        end else begin
            // End marker: report the outcome and return to the start state.
            n_out.byte_role = hup_pkg::ROLE_IGNORED;
            n_out.done_res  = 1'b1;
            if (!done_err) begin
                n_out.url_ok   = 1'b1;
                n_out.is_https = r_https;
                if (r_phase == hup_pkg::PH_PORT) begin
                    n_out.port_number = r_accum[15:0];
                end else begin
                    n_out.port_number = r_https ? hup_pkg::PORT_HTTPS : hup_pkg::PORT_HTTP;
                end
                n_out.path_defaulted = (r_phase != hup_pkg::PH_PATH);
                n_out.host_length    = 8'(r_host_count);
                n_out.path_length    = (r_phase == hup_pkg::PH_PATH) ? 10'(r_path_count)
                                                                    : 10'd0;
            end
            n_phase        = hup_pkg::PH_SCHEME;
            n_scheme_count = '0;
            n_https        = 1'b0;
            n_err          = 1'b0;
            n_term         = 1'b0;
            n_host_count   = '0;
            n_path_count   = '0;
            n_accum        = '0;
            n_sign         = 1'b0;
            n_neg          = 1'b0;
            n_digit        = 1'b0;
        end
    end

    // Parser state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hup_pkg::PH_SCHEME;
            r_scheme_count <= '0;
            r_https        <= 1'b0;
            r_err          <= 1'b0;
            r_term         <= 1'b0;
            r_host_count   <= '0;
            r_path_count   <= '0;
            r_accum        <= '0;
            r_sign         <= 1'b0;
            r_neg          <= 1'b0;
            r_digit        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_scheme_count <= n_scheme_count;
                r_https        <= n_https;
                r_err          <= n_err;
                r_term         <= n_term;
                r_host_count   <= n_host_count;
                r_path_count   <= n_path_count;
                r_accum        <= n_accum;
                r_sign         <= n_sign;
                r_neg          <= n_neg;
                r_digit        <= n_digit;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// File: design/http_url_stream_parser_unit.sv
// An accepted word goes into the queue, then is parsed into the result register.
// Throughput: one word per cycle unless the result sink stalls.
// A four-word queue separates the byte classifier from the parser, so either side
// may stall alone. The result register holds while the sink is not ready.
// Reset (synchronous, active low) empties the queue and returns the parser to the
// scheme start; no clearing pass is needed.
module http_url_stream_parser_unit #(
    parameter int HOST_BYTES = 256,
    parameter int PATH_BYTES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hup_in_if.sink    i_url,
    hup_out_if.source o_res
);

    hup_pkg::t_item   front_item;
    hup_pkg::t_item   q_item;
    hup_pkg::t_result result;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             push;

    assign i_url.ready = !q_full;
    assign push        = i_url.valid && !q_full;

    // Classify incoming bytes.
    hup_front u_front (
        .i_char_byte (i_url.char_byte),
        .i_is_end    (i_url.is_end),
        .o_item      (front_item)
    );

    // Decoupling queue.
    hup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Parse and register results.
    hup_back #(
        .HOST_BYTES (HOST_BYTES),
        .PATH_BYTES (PATH_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_result    (result)
    );

    assign o_res.byte_role      = result.byte_role;
    assign o_res.done_res       = result.done_res;
    assign o_res.url_ok         = result.url_ok;
    assign o_res.is_https       = result.is_https;
    assign o_res.port_number    = result.port_number;
    assign o_res.path_defaulted = result.path_defaulted;
    assign o_res.host_length    = result.host_length;
    assign o_res.path_length    = result.path_length;

endmodule

// File: sim/hup_url_checker.sv
`timescale 1ns / 1ps
// Checker for the URL parser: predicts every result word and compares it with the block.
module hup_url_checker #(
    parameter int HOST_BYTES = 256,
    parameter int PATH_BYTES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hup_in_if    i_url,
    hup_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [7:0] HTTP_LETTERS [4] = '{hup_pkg::CH_LOWER_H, hup_pkg::CH_LOWER_T,
                                                hup_pkg::CH_LOWER_T, hup_pkg::CH_LOWER_P};

    // Parser state of the URL being predicted.
    hup_pkg::t_phase url_phase;
    int              scheme_idx;
    logic            https_seen;
    logic            url_bad;
    logic            url_closed;
    int              host_tally;
    int              path_tally;
    int              port_acc;
    logic            sign_seen;
    logic            neg_seen;
    logic            digit_seen;

    hup_pkg::t_result predicted_results [$];
    int               fails = 0;
    int               queued_words = 0;

    assign o_fail_count = fails;
    assign o_pending    = queued_words;

    // Return to the scheme start, ready for the next URL.
    function automatic void clear_url();
        url_phase  = hup_pkg::PH_SCHEME;
        scheme_idx = 0;
        https_seen = 1'b0;
        url_bad    = 1'b0;
        url_closed = 1'b0;
        host_tally = 0;
        path_tally = 0;
        port_acc   = 0;
        sign_seen  = 1'b0;
        neg_seen   = 1'b0;
        digit_seen = 1'b0;
    endfunction

    function automatic logic [2:0] flag_error();
        url_bad = 1'b1;
        return hup_pkg::ROLE_IGNORED;
    endfunction

    function automatic logic port_ok();
        return digit_seen && !neg_seen && port_acc >= 1 &&
               port_acc <= int'(hup_pkg::PORT_MAX);
    endfunction

    function automatic logic [2:0] start_port();
        url_phase  = hup_pkg::PH_PORT;
        port_acc   = 0;
        sign_seen  = 1'b0;
        neg_seen   = 1'b0;
        digit_seen = 1'b0;
        return hup_pkg::ROLE_SEP;
    endfunction

    function automatic logic [2:0] start_path();
        url_phase  = hup_pkg::PH_PATH;
        path_tally = 1;
        if (path_tally >= PATH_BYTES) return flag_error();
        return hup_pkg::ROLE_PATH;
    endfunction

    function automatic logic [2:0] add_host();
        host_tally++;
        if (host_tally >= HOST_BYTES) return flag_error();
        return hup_pkg::ROLE_HOST;
    endfunction

    // The URL text has ended: decide whether the phase reached is a legal end.
    function automatic void close_url();
        url_closed = 1'b1;
        if (url_bad) return;
        case (url_phase)
            hup_pkg::PH_HOST, hup_pkg::PH_AFTER_HOST, hup_pkg::PH_PATH: ;
            hup_pkg::PH_PORT: begin
                if (!port_ok()) url_bad = 1'b1;
            end
            default: url_bad = 1'b1;
        endcase
    endfunction

    // Advance the parser by one URL byte and return the role of that byte.
    function automatic logic [2:0] take_byte(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= hup_pkg::CH_UPPER_A && c <= hup_pkg::CH_UPPER_Z) ?
             c + hup_pkg::CASE_OFFSET : c;
        case (url_phase)
            hup_pkg::PH_SCHEME: begin
                if (scheme_idx < 4 && lc == HTTP_LETTERS[scheme_idx]) begin
                    scheme_idx++;
                    if (scheme_idx == 4) url_phase = hup_pkg::PH_SCHEME_END;
                    return hup_pkg::ROLE_SCHEME;
                end
                return flag_error();
            end
            hup_pkg::PH_SCHEME_END: begin
                if (lc == hup_pkg::CH_LOWER_S) begin
                    https_seen = 1'b1;
                    url_phase  = hup_pkg::PH_COLON;
                    return hup_pkg::ROLE_SCHEME;
                end
                if (c == hup_pkg::CH_COLON) begin
                    url_phase = hup_pkg::PH_SLASH1;
                    return hup_pkg::ROLE_SEP;
                end
                return flag_error();
            end
            hup_pkg::PH_COLON: begin
                if (c == hup_pkg::CH_COLON) begin
                    url_phase = hup_pkg::PH_SLASH1;
                    return hup_pkg::ROLE_SEP;
                end
                return flag_error();
            end
            hup_pkg::PH_SLASH1: begin
                if (c == hup_pkg::CH_SLASH) begin
                    url_phase = hup_pkg::PH_SLASH2;
                    return hup_pkg::ROLE_SEP;
                end
                return flag_error();
            end
            hup_pkg::PH_SLASH2: begin
                if (c == hup_pkg::CH_SLASH) begin
                    url_phase = hup_pkg::PH_HOST_FIRST;
                    return hup_pkg::ROLE_SEP;
                end
                return flag_error();
            end
            hup_pkg::PH_HOST_FIRST: begin
                if (c == hup_pkg::CH_SLASH || c == hup_pkg::CH_COLON) return flag_error();
                if (c == hup_pkg::CH_LBRACK) begin
                    url_phase = hup_pkg::PH_BRACKET;
                    return hup_pkg::ROLE_BRACKET;
                end
                url_phase = hup_pkg::PH_HOST;
                return add_host();
            end
            hup_pkg::PH_HOST: begin
                if (c == hup_pkg::CH_COLON) return start_port();
                if (c == hup_pkg::CH_SLASH) return start_path();
                return add_host();
            end
            hup_pkg::PH_BRACKET: begin
                if (c == hup_pkg::CH_RBRACK) begin
                    if (host_tally == 0) return flag_error();
                    url_phase = hup_pkg::PH_AFTER_HOST;
                    return hup_pkg::ROLE_BRACKET;
                end
                return add_host();
            end
            hup_pkg::PH_AFTER_HOST: begin
                if (c == hup_pkg::CH_COLON) return start_port();
                if (c == hup_pkg::CH_SLASH) return start_path();
                return flag_error();
            end
            hup_pkg::PH_PORT: begin
                // Digits accumulate and saturate just above the largest port.
                if (c >= hup_pkg::CH_ZERO && c <= hup_pkg::CH_NINE) begin
                    digit_seen = 1'b1;
                    port_acc   = port_acc * 10 + int'(c - hup_pkg::CH_ZERO);
                    if (port_acc > int'(hup_pkg::PORT_SAT)) port_acc = int'(hup_pkg::PORT_SAT);
                    return hup_pkg::ROLE_PORT;
                end
                // Leading whitespace and one sign are allowed before the digits.
                if (!digit_seen && !sign_seen) begin
                    if (c == hup_pkg::CH_SPACE ||
                        (c >= hup_pkg::CH_TAB && c <= hup_pkg::CH_CR))
                        return hup_pkg::ROLE_PORT;
                    if (c == hup_pkg::CH_PLUS || c == hup_pkg::CH_MINUS) begin
                        sign_seen = 1'b1;
                        if (c == hup_pkg::CH_MINUS) neg_seen = 1'b1;
                        return hup_pkg::ROLE_PORT;
                    end
                    return flag_error();
                end
                if (digit_seen && c == hup_pkg::CH_SLASH) begin
                    if (!port_ok()) return flag_error();
                    return start_path();
                end
                return flag_error();
            end
            hup_pkg::PH_PATH: begin
                path_tally++;
                if (path_tally >= PATH_BYTES) return flag_error();
                return hup_pkg::ROLE_PATH;
            end
            default: return flag_error();
        endcase
    endfunction

    // Work out the result word of one accepted input word.
    function automatic hup_pkg::t_result parse_word(input logic [7:0] c, input logic last);
        hup_pkg::t_result r;
        r = '0;
        r.byte_role = hup_pkg::ROLE_IGNORED;
        if (!last) begin
            if (!url_closed && !url_bad) begin
                if (c == hup_pkg::CH_NUL) close_url();
                else r.byte_role = take_byte(c);
            end
        end else begin
            if (!url_closed) close_url();
            r.done_res = 1'b1;
            if (!url_bad) begin
                r.url_ok         = 1'b1;
                r.is_https       = https_seen;
                r.port_number    = (url_phase == hup_pkg::PH_PORT) ? 16'(port_acc) :
                                   (https_seen ? hup_pkg::PORT_HTTPS : hup_pkg::PORT_HTTP);
                r.path_defaulted = (url_phase != hup_pkg::PH_PATH);
                r.host_length    = 8'(host_tally);
                r.path_length    = (url_phase == hup_pkg::PH_PATH) ? 10'(path_tally) : 10'd0;
            end
            clear_url();
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    initial clear_url();

    // Queue a prediction for every accepted byte word and check every accepted result word.
    always @(posedge i_clk) begin : track_words
        hup_pkg::t_result want;
        if (i_rst_n) begin
            if (i_url.valid && i_url.ready)
                predicted_results.push_back(parse_word(i_url.char_byte, i_url.is_end));
            if (i_res.valid && i_res.ready) begin
                if (predicted_results.size() == 0) begin
                    fails++;
                    $display("%0t: result word with none expected: expected nothing, actual role %0d",
                             $time, i_res.byte_role);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("byte_role", want.byte_role, i_res.byte_role);
                    check_field("done_res", want.done_res, i_res.done_res);
                    check_field("url_ok", want.url_ok, i_res.url_ok);
                    check_field("is_https", want.is_https, i_res.is_https);
                    check_field("port_number", want.port_number, i_res.port_number);
                    check_field("path_defaulted", want.path_defaulted, i_res.path_defaulted);
                    check_field("host_length", want.host_length, i_res.host_length);
                    check_field("path_length", want.path_length, i_res.path_length);
                end
            end
            queued_words = predicted_results.size();
        end
    end

endmodule

// File: sim/http_url_stream_parser_unit_test.sv
`timescale 1ns / 1ps
// Test top for the URL parser: clock, reset, URL stimulus, sink stalls and the verdict.
module http_url_stream_parser_unit_test;

    localparam int HOST_LIMIT     = 256;
    localparam int PATH_LIMIT     = 1024;
    localparam int TOTAL_WORDS    = 1700;
    localparam int CALM_WORDS     = 250;
    localparam int WATCHDOG_LIMIT = 500;
    localparam logic [7:0] SCHEME_TEXT [5] = '{hup_pkg::CH_LOWER_H, hup_pkg::CH_LOWER_T,
                                               hup_pkg::CH_LOWER_T, hup_pkg::CH_LOWER_P,
                                               hup_pkg::CH_LOWER_S};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hup_in_if  url_ch ();
    hup_out_if res_ch ();

    int         fail_count;
    int         pending_words;
    logic       idle_on = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    logic [7:0] url_text [$];

    http_url_stream_parser_unit #(
        .HOST_BYTES (HOST_LIMIT),
        .PATH_BYTES (PATH_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_url   (url_ch),
        .o_res   (res_ch)
    );

    hup_url_checker #(
        .HOST_BYTES (HOST_LIMIT),
        .PATH_BYTES (PATH_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_url        (url_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always #5 i_clk = ~i_clk;

    // Result sink: ready drops at random while idling is on.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too many cycles without a word moving on either channel ends the run.
    always @(posedge i_clk) begin
        if ((url_ch.valid && url_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("http_url_stream_parser_unit test failed");
            $finish;
        end
    end

    // Offer one byte word; called and returning at a falling edge.
    task automatic push_word(input logic [7:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            url_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        url_ch.valid     <= 1'b1;
        url_ch.char_byte <= b;
        url_ch.is_end    <= last;
        @(posedge i_clk);
        while (!url_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send the URL text followed by its end marker, whose byte is don't-care.
    task automatic send_url();
        foreach (url_text[k]) push_word(url_text[k], 1'b0);
        push_word(8'($urandom), 1'b1);
    endtask

    // Build a URL. A nonzero host or path size gives a clean URL with that size forced;
    // otherwise the URL is mostly well formed with random damage now and then.
    task automatic compose_url(input int host_bytes, input int path_bytes);
        int         i;
        int         n;
        int         pick;
        int         val;
        logic [7:0] b;
        logic       bracketed;
        logic       clean;
        string      digits;
        url_text.delete();
        clean = (host_bytes != 0 || path_bytes != 0);

        // Plain noise now and then.
        if (!clean && $urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) url_text.push_back(8'($urandom));
            return;
        end

        // Scheme in random letter case, https about half the time.
        n = $urandom_range(0, 1) ? 5 : 4;
        for (i = 0; i < n; i++) begin
            b = SCHEME_TEXT[i];
            if ($urandom_range(0, 1)) b = b - hup_pkg::CASE_OFFSET;
            url_text.push_back(b);
        end
        url_text.push_back(hup_pkg::CH_COLON);
        url_text.push_back(hup_pkg::CH_SLASH);
        url_text.push_back(hup_pkg::CH_SLASH);

        // Host, plain or bracketed.
        if (host_bytes == 0) host_bytes = $urandom_range(1, 12);
        bracketed = !clean && $urandom_range(0, 4) == 0;
        if (bracketed) url_text.push_back(hup_pkg::CH_LBRACK);
        repeat (host_bytes) begin
            if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(1, 255));
            else b = 8'($urandom_range(8'h61, 8'h7A));
            if (b == hup_pkg::CH_LBRACK || b == hup_pkg::CH_RBRACK ||
                (!bracketed && (b == hup_pkg::CH_COLON || b == hup_pkg::CH_SLASH)))
                b = hup_pkg::CH_LOWER_H;
            url_text.push_back(b);
        end
        if (bracketed) url_text.push_back(hup_pkg::CH_RBRACK);

        // Optional port: whitespace, sign, leading zeros and out-of-range values.
        if (!clean && $urandom_range(0, 1)) begin
            url_text.push_back(hup_pkg::CH_COLON);
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 2);
                repeat (n)
                    url_text.push_back($urandom_range(0, 1) ? hup_pkg::CH_SPACE :
                                       8'($urandom_range(hup_pkg::CH_TAB, hup_pkg::CH_CR)));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) url_text.push_back(hup_pkg::CH_MINUS);
            else if (pick == 1) url_text.push_back(hup_pkg::CH_PLUS);
            if ($urandom_range(0, 11) != 0) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0: val = 0;
                    1: val = 65535;
                    2: val = 65536;
                    3: val = $urandom_range(65537, 9999999);
                    4: val = 1;
                    default: val = $urandom_range(1, 65535);
                endcase
                if ($urandom_range(0, 5) == 0) begin
                    n = $urandom_range(1, 2);
                    repeat (n) url_text.push_back(hup_pkg::CH_ZERO);
                end
                digits = $sformatf("%0d", val);
                for (i = 0; i < digits.len(); i++) url_text.push_back(digits[i]);
            end
        end

        // Optional path of arbitrary nonzero bytes.
        if (path_bytes == 0 && !clean && $urandom_range(0, 4) < 3)
            path_bytes = $urandom_range(1, 20);
        if (path_bytes > 0) begin
            url_text.push_back(hup_pkg::CH_SLASH);
            repeat (path_bytes - 1) url_text.push_back(8'($urandom_range(1, 255)));
        end

        if (!clean) begin
            // Early terminator with trailing bytes that must be ignored.
            if ($urandom_range(0, 9) == 0) begin
                url_text.push_back(hup_pkg::CH_NUL);
                n = $urandom_range(0, 3);
                repeat (n) url_text.push_back(8'($urandom));
            end
            // Damage: one corrupted byte, or a cut-off URL.
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, url_text.size() - 1);
                url_text[n] = 8'($urandom);
            end
            if ($urandom_range(0, 15) == 0) begin
                n = $urandom_range(0, url_text.size() - 1);
                while (url_text.size() > n) void'(url_text.pop_back());
            end
        end
    endtask

    // Main stimulus.
    initial begin : stimulus
        int url_idx;
        int words_sent;
        url_ch.valid     = 1'b0;
        url_ch.char_byte = 8'h00;
        url_ch.is_end    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        // Directed: every role, mixed-case https, bracketed host with a high byte,
        // spaced and signed port, then a URL cut short by a zero byte.
        url_text = '{"h", "T", "t", "P", "s", ":", "/", "/", "[", 8'hFF, "]",
                     ":", " ", "+", "9", "/"};
        send_url();
        url_text = '{"h", "t", "t", "p", ":", "/", "/", "a", 8'h00, "z"};
        send_url();

        // Random URLs; two forced ones run into the host and path size limits.
        url_idx    = 0;
        words_sent = 0;
        while (words_sent < TOTAL_WORDS) begin
            if (words_sent < TOTAL_WORDS - CALM_WORDS)
                idle_on = ($urandom_range(0, 3) != 0);
            else
                idle_on = 1'b0;
            case (url_idx)
                3:  compose_url(HOST_LIMIT, 0);
                6:  compose_url(0, PATH_LIMIT);
                default: compose_url(0, 0);
            endcase
            words_sent += url_text.size() + 1;
            send_url();
            // Hold the sender until the block has drained completely.
            if (url_idx == 10) begin
                url_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending_words != 0) @(negedge i_clk);
            end
            url_idx++;
        end

        // Drain, allow the block's latency for stray words, then report.
        url_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("http_url_stream_parser_unit test passed");
        else
            $display("http_url_stream_parser_unit test failed");
        $finish;
    end

endmodule

// File: http_url_stream_parser_unit.f
design/hup_pkg.sv
design/hup_ifs.sv
design/hup_front.sv
design/hup_queue.sv
design/hup_back.sv
design/http_url_stream_parser_unit.sv
sim/hup_url_checker.sv
sim/http_url_stream_parser_unit_test.sv
